### rtl/nmea_rmc_position_parser_macros.svh
// assertion helpers shared by the parser top level
`ifndef NMEA_RMC_POSITION_PARSER_MACROS_SVH
`define NMEA_RMC_POSITION_PARSER_MACROS_SVH

// same-cycle implication, checked outside reset
`define NRP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define NRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/nrp_pkg.sv
package nrp_pkg;

  // ascii codes used by the parser
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_W     = 8'h57;

  // sentence header length and field numbers of interest
  localparam logic [2:0] HDR_LEN    = 3'd6;
  localparam logic [2:0] HDR_MISS   = 3'd7;
  localparam logic [3:0] FLD_STATUS = 4'd2;
  localparam logic [3:0] FLD_LAT    = 4'd3;
  localparam logic [3:0] FLD_LAT_H  = 4'd4;
  localparam logic [3:0] FLD_LON    = 4'd5;
  localparam logic [3:0] FLD_LON_H  = 4'd6;
  localparam logic [2:0] MIN_NUM_LEN = 3'd4;

  localparam logic [23:0] INT_SAT = 24'hFFFFFF;

  // reciprocal constants: floor(n/100) = (n*RECIP100)>>31 for 24 bit n,
  // floor(y/60) = (y*RECIP60)>>36 for 30 bit y
  localparam logic [24:0] RECIP100   = 25'd21474837;
  localparam int          RECIP100_SH = 31;
  localparam logic [30:0] RECIP60    = 31'd1145324613;
  localparam int          RECIP60_SH = 36;
  localparam logic [23:0] E7         = 24'd10000000;
  localparam logic [31:0] SAT_LIMIT  = 32'd2000000000;

  // raw number as collected by the parser
  typedef struct packed {
    logic [23:0] int_part;
    logic [23:0] frac_part;
    logic [2:0]  frac_count;
    logic        long_enough;
  } num_raw_t;

  // one queued line result
  typedef struct packed {
    num_raw_t lat;
    num_raw_t lon;
    logic     lat_neg;
    logic     lon_neg;
  } line_job_t;

  // "$GPRMC" header characters
  function automatic logic [7:0] header_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h24;
      3'd1:    ch = 8'h47;
      3'd2:    ch = 8'h50;
      3'd3:    ch = 8'h52;
      3'd4:    ch = 8'h4D;
      3'd5:    ch = 8'h43;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // powers of ten up to 10^7
  function automatic logic [23:0] pow10(input logic [2:0] e);
    logic [23:0] p;
    case (e)
      3'd0:    p = 24'd1;
      3'd1:    p = 24'd10;
      3'd2:    p = 24'd100;
      3'd3:    p = 24'd1000;
      3'd4:    p = 24'd10000;
      3'd5:    p = 24'd100000;
      3'd6:    p = 24'd1000000;
      default: p = 24'd10000000;
    endcase
    return p;
  endfunction

endpackage

### rtl/nrp_front.sv
module nrp_front #(
  parameter int FRAC_DIGITS = 5,
  parameter int MAX_FIELDS  = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [7:0]         rx_byte,
  output logic               push,
  output nrp_pkg::line_job_t push_job
);
  import nrp_pkg::*;

  typedef enum logic [2:0] {
    PH_INT  = 3'b001,
    PH_FRAC = 3'b010,
    PH_STOP = 3'b100
  } phase_t;

  localparam logic [3:0] LAST_FIELD = 4'(MAX_FIELDS - 1);
  localparam logic [2:0] FRAC_MAX   = 3'(FRAC_DIGITS);

  logic        nonempty_r, nonempty_nxt;
  logic [2:0]  prefix_r, prefix_nxt;
  logic        hdr_ok_r, hdr_ok_nxt;
  logic [3:0]  fidx_r, fidx_nxt;
  logic [2:0]  flen_r, flen_nxt;
  logic        status_r, status_nxt;
  phase_t      phase_r, phase_nxt;
  logic [23:0] int_r, int_nxt;
  logic [23:0] frac_r, frac_nxt;
  logic [2:0]  fcnt_r, fcnt_nxt;
  num_raw_t    lat_r, lat_nxt, lon_r, lon_nxt;
  logic        lat_neg_r, lat_neg_nxt, lon_neg_r, lon_neg_nxt;

  logic        is_eol, is_print, is_digit, field_sep;
  logic [3:0]  digit;
  logic [27:0] int_mul;
  num_raw_t    cur_num, empty_num;

  assign is_eol    = (rx_byte == CH_LF) || (rx_byte == CH_CR);
  assign is_print  = (rx_byte >= CH_SPACE) && (rx_byte <= CH_TILDE);
  assign is_digit  = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign digit     = 4'(rx_byte - CH_ZERO);
  assign field_sep = (rx_byte == CH_COMMA) && (fidx_r < LAST_FIELD);
  assign int_mul   = {4'b0, int_r} * 28'd10 + 28'(digit);

  // the number of the field now being read
  always_comb begin
    cur_num.int_part    = int_r;
    cur_num.frac_part   = frac_r;
    cur_num.frac_count  = fcnt_r;
    cur_num.long_enough = (flen_r >= MIN_NUM_LEN);
    empty_num = '0;
  end

  // line end result, with the open field taken in
  always_comb begin
    push_job.lat     = (fidx_r == FLD_LAT) ? cur_num : lat_r;
    push_job.lon     = (fidx_r == FLD_LON) ? cur_num : lon_r;
    push_job.lat_neg = lat_neg_r;
    push_job.lon_neg = lon_neg_r;
    push = accept && is_eol && nonempty_r && hdr_ok_r && status_r;
  end

  // byte parser
  always_comb begin
    nonempty_nxt = nonempty_r;
    prefix_nxt   = prefix_r;
    hdr_ok_nxt   = hdr_ok_r;
    fidx_nxt     = fidx_r;
    flen_nxt     = flen_r;
    status_nxt   = status_r;
    phase_nxt    = phase_r;
    int_nxt      = int_r;
    frac_nxt     = frac_r;
    fcnt_nxt     = fcnt_r;
    lat_nxt      = lat_r;
    lon_nxt      = lon_r;
    lat_neg_nxt  = lat_neg_r;
    lon_neg_nxt  = lon_neg_r;
    if (accept && is_eol) begin
      nonempty_nxt = 1'b0;
      prefix_nxt   = '0;
      hdr_ok_nxt   = 1'b0;
      fidx_nxt     = '0;
      flen_nxt     = '0;
      status_nxt   = 1'b0;
      phase_nxt    = PH_INT;
      int_nxt      = '0;
      frac_nxt     = '0;
      fcnt_nxt     = '0;
      lat_nxt      = empty_num;
      lon_nxt      = empty_num;
      lat_neg_nxt  = 1'b0;
      lon_neg_nxt  = 1'b0;
    end else if (accept && is_print) begin
      nonempty_nxt = 1'b1;
      // header match
      if (prefix_r < HDR_LEN) begin
        if (rx_byte == header_char(prefix_r)) begin
          prefix_nxt = prefix_r + 3'd1;
          if (prefix_r == HDR_LEN - 3'd1) begin
            hdr_ok_nxt = 1'b1;
          end
        end else begin
          prefix_nxt = HDR_MISS;
        end
      end
      if (field_sep) begin
        // close the field
        if (fidx_r == FLD_LAT) begin
          lat_nxt = cur_num;
        end else if (fidx_r == FLD_LON) begin
          lon_nxt = cur_num;
        end
        fidx_nxt  = fidx_r + 4'd1;
        flen_nxt  = '0;
        phase_nxt = PH_INT;
        int_nxt   = '0;
        frac_nxt  = '0;
        fcnt_nxt  = '0;
      end else begin
        if (fidx_r == FLD_STATUS) begin
          status_nxt = (flen_r == 3'd0) && (rx_byte == CH_A);
        end
        if ((flen_r == 3'd0) && ((rx_byte == CH_S) || (rx_byte == CH_W))) begin
          if (fidx_r == FLD_LAT_H) begin
            lat_neg_nxt = 1'b1;
          end else if (fidx_r == FLD_LON_H) begin
            lon_neg_nxt = 1'b1;
          end
        end
        // number syntax
        case (phase_r)
          PH_INT: begin
            if (is_digit) begin
              int_nxt = (int_mul > {4'b0, INT_SAT}) ? INT_SAT : int_mul[23:0];
            end else if (rx_byte == CH_DOT) begin
              phase_nxt = PH_FRAC;
            end else begin
              phase_nxt = PH_STOP;
            end
          end
          PH_FRAC: begin
            if (is_digit) begin
              if (fcnt_r < FRAC_MAX) begin
                frac_nxt = 24'(frac_r * 24'd10) + 24'(digit);
                fcnt_nxt = fcnt_r + 3'd1;
              end
            end else begin
              phase_nxt = PH_STOP;
            end
          end
          default: begin
            phase_nxt = PH_STOP;
          end
        endcase
        if (flen_r < 3'd7) begin
          flen_nxt = flen_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nonempty_r <= 1'b0;
      prefix_r   <= '0;
      hdr_ok_r   <= 1'b0;
      fidx_r     <= '0;
      flen_r     <= '0;
      status_r   <= 1'b0;
      phase_r    <= PH_INT;
      int_r      <= '0;
      frac_r     <= '0;
      fcnt_r     <= '0;
      lat_r      <= '0;
      lon_r      <= '0;
      lat_neg_r  <= 1'b0;
      lon_neg_r  <= 1'b0;
    end else begin
      nonempty_r <= nonempty_nxt;
      prefix_r   <= prefix_nxt;
      hdr_ok_r   <= hdr_ok_nxt;
      fidx_r     <= fidx_nxt;
      flen_r     <= flen_nxt;
      status_r   <= status_nxt;
      phase_r    <= phase_nxt;
      int_r      <= int_nxt;
      frac_r     <= frac_nxt;
      fcnt_r     <= fcnt_nxt;
      lat_r      <= lat_nxt;
      lon_r      <= lon_nxt;
      lat_neg_r  <= lat_neg_nxt;
      lon_neg_r  <= lon_neg_nxt;
    end
  end

endmodule

### rtl/nrp_queue.sv
module nrp_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  nrp_pkg::line_job_t push_job,
  output logic               full,
  input  logic               pop,
  output logic               valid,
  output nrp_pkg::line_job_t pop_job
);
  import nrp_pkg::*;

  line_job_t  mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;

  assign full    = (count_r == 2'd2);
  assign valid   = (count_r != 2'd0);
  assign pop_job = mem_r[rd_ptr_r];

  // occupancy
  always_comb begin
    count_nxt = count_r;
    if (push && !(pop && valid)) begin
      count_nxt = count_r + 2'd1;
    end else if (!push && pop && valid) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop && valid) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

### rtl/nrp_back.sv
module nrp_back #(
  parameter int FRAC_DIGITS = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  input  nrp_pkg::line_job_t job,
  output logic               job_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_lat_e7,
  output logic signed [31:0] out_lon_e7
);
  import nrp_pkg::*;

  // minutes scale: 10^7 / 10^FRAC_DIGITS
  localparam logic [23:0] MIN_SCALE = pow10(3'(7 - FRAC_DIGITS));
  localparam logic [2:0]  FRAC_MAX  = 3'(FRAC_DIGITS);

  typedef struct packed {
    logic [23:0] int_part;
    logic [17:0] deg;
    logic [23:0] frac_sc;
    logic        ok;
    logic        neg;
  } s1_t;

  typedef struct packed {
    logic [29:0] min_e7x60;
    logic [40:0] deg_e7;
    logic        ok;
    logic        neg;
  } s2_t;

  typedef struct packed {
    logic [24:0] min_e7;
    logic [40:0] deg_e7;
    logic        ok;
    logic        neg;
  } s3_t;

  num_raw_t    lane_in [2];
  logic        lane_neg [2];
  s1_t         s1_r [2], s1_nxt [2];
  s2_t         s2_r [2], s2_nxt [2];
  s3_t         s3_r [2], s3_nxt [2];
  logic [31:0] res_nxt [2];
  logic        s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic        adv;
  logic [31:0] lat_r, lon_r;

  assign adv       = !out_v_r || out_ready;
  assign job_pop   = job_valid && adv;
  assign out_valid = out_v_r;
  assign out_lat_e7 = lat_r;
  assign out_lon_e7 = lon_r;

  always_comb begin
    lane_in[0]  = job.lat;
    lane_in[1]  = job.lon;
    lane_neg[0] = job.lat_neg;
    lane_neg[1] = job.lon_neg;
  end

  // per-lane datapath
  always_comb begin
    logic [48:0] p100;
    logic [47:0] pfrac;
    logic [23:0] mins;
    logic [31:0] ymix;
    logic [60:0] p60;
    logic [41:0] total;
    logic [31:0] mag;
    for (int i = 0; i < 2; i++) begin
      // stage 1: degrees by reciprocal, fraction scaled to full digits
      p100  = {25'b0, lane_in[i].int_part} * {24'b0, RECIP100};
      pfrac = lane_in[i].frac_part * pow10(FRAC_MAX - lane_in[i].frac_count);
      s1_nxt[i].int_part = lane_in[i].int_part;
      s1_nxt[i].deg      = p100[RECIP100_SH +: 18];
      s1_nxt[i].frac_sc  = pfrac[23:0];
      s1_nxt[i].ok       = lane_in[i].long_enough;
      s1_nxt[i].neg      = lane_neg[i];
      // stage 2: minutes times 10^7, degrees times 10^7
      mins = s1_r[i].int_part - 24'({6'b0, s1_r[i].deg} * 24'd100);
      ymix = 32'({8'b0, mins} * 32'(E7)) + 32'({8'b0, s1_r[i].frac_sc} * {8'b0, MIN_SCALE});
      s2_nxt[i].min_e7x60 = ymix[29:0];
      s2_nxt[i].deg_e7    = 41'({23'b0, s1_r[i].deg} * {17'b0, E7});
      s2_nxt[i].ok        = s1_r[i].ok;
      s2_nxt[i].neg       = s1_r[i].neg;
      // stage 3: divide minutes by 60
      p60 = {31'b0, s2_r[i].min_e7x60} * {30'b0, RECIP60};
      s3_nxt[i].min_e7 = p60[RECIP60_SH +: 25];
      s3_nxt[i].deg_e7 = s2_r[i].deg_e7;
      s3_nxt[i].ok     = s2_r[i].ok;
      s3_nxt[i].neg    = s2_r[i].neg;
      // output: sum, saturate, zero if the field was too short, sign
      total = {1'b0, s3_r[i].deg_e7} + {17'b0, s3_r[i].min_e7};
      mag   = (total > {10'b0, SAT_LIMIT}) ? SAT_LIMIT : total[31:0];
      if (!s3_r[i].ok) begin
        mag = '0;
      end
      res_nxt[i] = s3_r[i].neg ? (32'd0 - mag) : mag;
    end
  end

  // pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r  <= job_valid;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      out_v_r <= s3_v_r;
    end
  end

  // pipeline data
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 2; i++) begin
        s1_r[i] <= s1_nxt[i];
        s2_r[i] <= s2_nxt[i];
        s3_r[i] <= s3_nxt[i];
      end
      lat_r <= res_nxt[0];
      lon_r <= res_nxt[1];
    end
  end

endmodule

### rtl/nmea_rmc_position_parser.sv
// NMEA RMC position parser
// Input channel: one received character per word on in_rx_byte (in_valid /
// in_ready). CR or LF closes a line; other control bytes are dropped.
// Output channel: one word of out_lat_e7 / out_lon_e7 (1e-7 degree, signed,
// saturated at +-2000000000) for every line that starts with $GPRMC and has
// status "A"; other lines give nothing.
// Throughput: one character per cycle. in_ready drops only while the
// two-entry line queue is full, which takes several stalled result words.
// Path: the line-end character is written into the line queue, then its
// result passes a three-stage converter for degrees, minutes and the divide
// by 60, then the output register; the converter advances only while the
// output side is free.
// Reset (rst_n low, synchronous): clears the line state, empties the queue
// and drops any result in flight.
// A stalled receiver holds the output word and the converter pipeline;
// characters keep being taken until the queue fills.
`include "nmea_rmc_position_parser_macros.svh"

module nmea_rmc_position_parser #(
  parameter int FRAC_DIGITS = 5,
  parameter int MAX_FIELDS  = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_lat_e7,
  output logic signed [31:0] out_lon_e7
);
  import nrp_pkg::*;

  logic      accept;
  logic      q_push, q_full, q_pop, q_valid;
  line_job_t push_job, pop_job;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // character parser
  nrp_front #(
    .FRAC_DIGITS(FRAC_DIGITS),
    .MAX_FIELDS (MAX_FIELDS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .rx_byte (in_rx_byte),
    .push    (q_push),
    .push_job(push_job)
  );

  // line result queue
  nrp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_job(push_job),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .pop_job (pop_job)
  );

  // coordinate converter
  nrp_back #(
    .FRAC_DIGITS(FRAC_DIGITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_valid),
    .job       (pop_job),
    .job_pop   (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_lat_e7(out_lat_e7),
    .out_lon_e7(out_lon_e7)
  );

  // checks
  `NRP_ASSERT_IMP(a_no_overflow, q_push, !q_full, "line queue overflow")
  `NRP_ASSERT_IMP(a_pop_valid, q_pop, q_valid, "pop from empty line queue")
  `NRP_ASSERT_NEXT(a_push_held, q_push, q_valid, "pushed line lost")
  `NRP_ASSERT_IMP(a_out_range, out_valid,
    (out_lat_e7 >= -32'sd2000000000) && (out_lat_e7 <= 32'sd2000000000) &&
    (out_lon_e7 >= -32'sd2000000000) && (out_lon_e7 <= 32'sd2000000000),
    "result out of range")

endmodule
